// File: sv/tehs_pkg.sv
// Shared constants, types and action codes of the timed event heap scheduler.
package tehs_pkg;
    localparam int CAPACITY = 64;
    localparam int ID_WIDTH = 16;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_TICK     = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    typedef struct packed {
        logic signed [31:0]    t;
        logic [ID_WIDTH-1:0]   id;
    } entry_t;
endpackage

// File: sv/tehs_if.sv
// Request and response channel interfaces of the timed event heap scheduler.
interface tehs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] delay_cycles;
    logic [15:0]        event_id;
    logic [30:0]        tick_amount;
    modport source (output valid, action, delay_cycles, event_id, tick_amount, input ready);
    modport sink   (input valid, action, delay_cycles, event_id, tick_amount, output ready);
endinterface

interface tehs_rsp_if;
    logic               valid;
    logic               ready;
    logic               fired;
    logic [15:0]        fired_id;
    logic signed [31:0] overshoot;
    logic [6:0]         pending_count;
    logic               status;
    modport source (output valid, fired, fired_id, overshoot, pending_count, status,
                    input ready);
    modport sink   (input valid, fired, fired_id, overshoot, pending_count, status,
                    output ready);
endinterface

// File: sv/timed_event_heap_scheduler.sv
// Top level of the timed event heap scheduler: a binary min-heap held in one RAM.
//
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  req      | in        | action, delay_cycles, event_id, tick_amount
//  rsp      | out       | fired, fired_id, overshoot, pending_count, status
//
// A schedule moves the new event up the heap a level at a time until it stops below its
// parent or reaches the root; a schedule on a full heap is dropped. A tick first ages
// every pending event in a sweep through the heap RAM; when the root then fires, the
// last entry moves to the root and sinks a level at a time. A clear empties the heap.
// One request is worked on at a time; a request is taken while the previous response
// still waits in the output register, and a stalled response holds the block in its
// final state until the register frees up.
// Reset empties the heap at once; the RAM contents are not cleared.
module timed_event_heap_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    tehs_req_if.sink    req,
    tehs_rsp_if.source  rsp
);
    import tehs_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP      = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_AGE     = 4'd3;
    localparam logic [3:0] S_FIRE    = 4'd4;
    localparam logic [3:0] S_DN_LOAD = 4'd5;
    localparam logic [3:0] S_DN      = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    // The heap RAM: one write port and two registered read ports.
    entry_t mem [CAPACITY];
    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    entry_t        wdata, rdata_a_reg, rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic          pend_reg, pend_next;
    entry_t        val_reg, val_next;
    entry_t        root_reg, root_next;
    logic [30:0]   tick_reg, tick_next;
    logic          res_fired_reg, res_fired_next;
    logic          res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_fired_reg, out_status_reg;
    logic [15:0]   out_id_reg;
    logic signed [31:0] out_over_reg;
    logic [6:0]    out_count_reg;

    // Aging of the word coming back from the sweep, saturating at the most negative time.
    logic signed [32:0] aged_diff;
    entry_t             aged;
    always_comb
    begin
        aged_diff = {rdata_a_reg.t[31], rdata_a_reg.t} - $signed({2'b00, tick_reg});
        aged.id   = rdata_a_reg.id;
        if (aged_diff[32] && !aged_diff[31])
        begin
            aged.t = 32'sh8000_0000;
        end
        else
        begin
            aged.t = aged_diff[31:0];
        end
    end

    logic [CW-1:0] parent;
    logic [CW:0]   lchild, rchild;
    logic          l_ok, r_ok;
    logic          take_l, take_r;
    assign parent = (pos_reg - CW'(1)) >> 1;
    assign lchild = {pos_reg, 1'b1};
    assign rchild = {pos_reg, 1'b0} + (CW+1)'(2);
    assign l_ok   = lchild < {1'b0, count_reg};
    assign r_ok   = rchild < {1'b0, count_reg};

    // The right child wins only when it is strictly below the better of the hole and the left.
    always_comb
    begin
        take_l = l_ok && (rdata_a_reg.t < val_reg.t);
        if (take_l)
        begin
            take_r = r_ok && (rdata_b_reg.t < rdata_a_reg.t);
        end
        else
        begin
            take_r = r_ok && (rdata_b_reg.t < val_reg.t);
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        widx_next       = widx_reg;
        pend_next       = pend_reg;
        val_next        = val_reg;
        root_next       = root_reg;
        tick_next       = tick_reg;
        res_fired_next  = res_fired_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        we              = 1'b0;
        waddr           = pos_reg[AW-1:0];
        wdata           = val_reg;
        raddr_a         = parent[AW-1:0];
        raddr_b         = rchild[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_fired_next  = 1'b0;
                    res_status_next = 1'b0;
                    val_next.t      = req.delay_cycles;
                    val_next.id     = ID_WIDTH'(req.event_id);
                    tick_next       = req.tick_amount;
                    pos_next        = count_reg;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    state_next      = S_DONE;
                    case (req.action)
                        ACT_SCHEDULE:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_UP;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_AGE;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (val_reg.t < rdata_a_reg.t)
                begin
                    wdata      = rdata_a_reg;
                    pos_next   = parent;
                    state_next = S_UP;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_AGE:
            begin
                // Read entry idx while the aged copy of the previous entry is written back.
                raddr_a = idx_reg[AW-1:0];
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = widx_reg;
                    wdata = aged;
                    if (widx_reg == '0)
                    begin
                        root_next = aged;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    widx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIRE;
                end
            end
            S_FIRE:
            begin
                raddr_a    = AW'(count_reg - CW'(1));
                state_next = S_DONE;
                if (root_reg.t <= 0)
                begin
                    res_fired_next = 1'b1;
                    count_next     = count_reg - CW'(1);
                    if (count_reg != CW'(1))
                    begin
                        state_next = S_DN_LOAD;
                    end
                end
            end
            S_DN_LOAD:
            begin
                val_next   = rdata_a_reg;
                pos_next   = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                raddr_a    = lchild[AW-1:0];
                raddr_b    = rchild[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (take_r)
                begin
                    wdata      = rdata_b_reg;
                    pos_next   = rchild[CW-1:0];
                    state_next = S_DN;
                end
                else if (take_l)
                begin
                    wdata      = rdata_a_reg;
                    pos_next   = lchild[CW-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        widx_reg       <= widx_next;
        val_reg        <= val_next;
        root_reg       <= root_next;
        tick_reg       <= tick_next;
        res_fired_reg  <= res_fired_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_fired_reg  <= res_fired_reg;
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_fired_reg ? 16'(root_reg.id) : 16'd0;
            out_over_reg   <= res_fired_reg ? root_reg.t : 32'sd0;
            out_count_reg  <= 7'(count_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.fired         = out_fired_reg;
    assign rsp.fired_id      = out_id_reg;
    assign rsp.overshoot     = out_over_reg;
    assign rsp.pending_count = out_count_reg;
    assign rsp.status        = out_status_reg;
endmodule

// File: sv/tehs_checker.sv
// Port-level checks of the timed event heap scheduler, bound to its top level.
module tehs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        fired,
    input logic [15:0] fired_id,
    input logic [31:0] overshoot,
    input logic [6:0]  pending_count,
    input logic        status
);
    import tehs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fired_id == 16'd0 && overshoot == 32'd0)
        else $error("fields set without a fired event");

    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> overshoot[31] || overshoot == 32'd0)
        else $error("fired event with positive remaining time");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !fired && pending_count == 7'(CAPACITY))
        else $error("dropped schedule with heap not full");
endmodule

bind timed_event_heap_scheduler tehs_checker u_tehs_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(rsp.valid), .out_ready(rsp.ready),
    .fired(rsp.fired), .fired_id(rsp.fired_id), .overshoot(rsp.overshoot),
    .pending_count(rsp.pending_count), .status(rsp.status)
);

// File: test/timed_event_heap_scheduler_tb.sv
// Testbench for the timed event heap scheduler: random and directed requests against a model.
`timescale 1ns / 100ps

module timed_event_heap_scheduler_tb;
    import tehs_pkg::*;

    // Action code 3 is unused by the block; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int TIMEOUT_CYCLES = 1500000;
    localparam logic signed [31:0] TIME_FLOOR = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] delay_cycles;
        logic [15:0]        event_id;
        logic [30:0]        tick_amount;
    } request_t;

    typedef struct packed {
        logic               fired;
        logic [15:0]        fired_id;
        logic signed [31:0] overshoot;
        logic [6:0]         pending_count;
        logic               status;
    } response_t;

    logic clk;
    logic rst_n;

    tehs_req_if in_req ();
    tehs_rsp_if out_rsp ();

    timed_event_heap_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (in_req.sink),
        .rsp     (out_rsp.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Model of the heap. Only entries below model_count, or just written at it, are ever read.
    logic signed [31:0] model_time [CAPACITY];
    logic [15:0]        model_ident [CAPACITY];
    int                 model_count;

    request_t  pending_reqs [$];
    response_t expected_rsps [$];

    int error_count;
    int cycle_count;
    int fired_seen;
    int full_seen;
    int send_idle_pct;
    int recv_stall_pct;

    task automatic swap_entries(input int a, input int b);
        logic signed [31:0] t;
        logic [15:0]        d;
        begin
            t = model_time[a];
            d = model_ident[a];
            model_time[a] = model_time[b];
            model_ident[a] = model_ident[b];
            model_time[b] = t;
            model_ident[b] = d;
        end
    endtask

    // Computes the response of one request and updates the model heap.
    task automatic schedule_model(input request_t rq, output response_t rs);
        int pos;
        int up;
        int best;
        int l;
        int r;
        longint aged;
        begin
            rs = '0;
            if (rq.action == ACT_SCHEDULE) begin
                if (model_count >= CAPACITY) begin
                    rs.status = 1'b1;
                end
                else begin
                    model_time[model_count] = rq.delay_cycles;
                    model_ident[model_count] = rq.event_id;
                    pos = model_count;
                    // Bubble up, stopping on greater-or-equal.
                    while (pos > 0) begin
                        up = (pos - 1) >> 1;
                        if (model_time[pos] >= model_time[up])
                            break;
                        swap_entries(pos, up);
                        pos = up;
                    end
                    model_count++;
                end
            end
            else if (rq.action == ACT_TICK) begin
                if (model_count > 0) begin
                    for (int i = 0; i < model_count; i++) begin
                        aged = longint'(model_time[i]) - longint'({1'b0, rq.tick_amount});
                        if (aged < longint'(TIME_FLOOR))
                            model_time[i] = TIME_FLOOR;
                        else
                            model_time[i] = aged[31:0];
                    end
                    if (model_time[0] <= 0) begin
                        rs.fired = 1'b1;
                        rs.fired_id = model_ident[0];
                        rs.overshoot = model_time[0];
                        model_count--;
                        if (model_count > 0) begin
                            model_time[0] = model_time[model_count];
                            model_ident[0] = model_ident[model_count];
                            pos = 0;
                            // Sink the moved entry, left child first, strict compare.
                            forever begin
                                best = pos;
                                l = 2 * pos + 1;
                                r = 2 * pos + 2;
                                if (l < model_count && model_time[l] < model_time[best])
                                    best = l;
                                if (r < model_count && model_time[r] < model_time[best])
                                    best = r;
                                if (best == pos)
                                    break;
                                swap_entries(pos, best);
                                pos = best;
                            end
                        end
                    end
                end
            end
            else if (rq.action == ACT_CLEAR) begin
                model_count = 0;
            end
            rs.pending_count = model_count[6:0];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
            error_count++;
        end
    endtask

    function automatic request_t make_req(input logic [1:0] act, input logic [31:0] dly,
                                          input logic [15:0] id, input logic [30:0] tk);
        request_t rq;
        begin
            rq.action = act;
            rq.delay_cycles = dly;
            rq.event_id = id;
            rq.tick_amount = tk;
            return rq;
        end
    endfunction

    // Delay values mostly small so that events fire, with occasional extremes.
    function automatic logic [31:0] rand_delay();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                return 32'($urandom_range(0, 200)) - 32'd20;
            else if (sel == 6)
                return $urandom();
            else if (sel == 7)
                return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            else if (sel == 8)
                return 32'h8000_0000 + 32'($urandom_range(0, 3));
            else
                return 32'($urandom_range(0, 3));
        end
    endfunction

    function automatic logic [30:0] rand_tick();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                return 31'($urandom_range(0, 60));
            else if (sel == 7)
                return 31'($urandom());
            else if (sel == 8)
                return 31'h7FFF_FFFF;
            else
                return 31'd0;
        end
    endfunction

    // Driver: presents queued requests at the falling edge with random idle gaps.
    // Valid stays high until the request is taken at a rising edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_req.valid <= 1'b0;
        end
        else if (in_req.valid && !in_req.ready) begin
            // Request still waiting; hold it.
        end
        else begin
            if (in_req.valid && in_req.ready)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
                in_req.valid <= 1'b1;
                in_req.action <= pending_reqs[0].action;
                in_req.delay_cycles <= pending_reqs[0].delay_cycles;
                in_req.event_id <= pending_reqs[0].event_id;
                in_req.tick_amount <= pending_reqs[0].tick_amount;
            end
            else begin
                in_req.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls are drawn at the falling edge as well.
    always @(negedge clk) begin
        if (!rst_n)
            out_rsp.ready <= 1'b0;
        else
            out_rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Accepted requests feed the model; it runs at the rising edge of acceptance.
    always @(posedge clk) begin
        response_t rs;
        request_t  rq;
        if (rst_n && in_req.valid && in_req.ready) begin
            rq = make_req(in_req.action, in_req.delay_cycles, in_req.event_id,
                          in_req.tick_amount);
            schedule_model(rq, rs);
            expected_rsps.push_back(rs);
        end
    end

    // Monitor: compares each accepted response with the oldest expectation.
    always @(posedge clk) begin
        response_t want;
        if (rst_n && out_rsp.valid && out_rsp.ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response", 32'd1, 32'd0);
            end
            else begin
                want = expected_rsps.pop_front();
                if (out_rsp.fired !== want.fired)
                    report_mismatch("fired", 32'(out_rsp.fired), 32'(want.fired));
                if (out_rsp.fired_id !== want.fired_id)
                    report_mismatch("fired_id", 32'(out_rsp.fired_id), 32'(want.fired_id));
                if (out_rsp.overshoot !== want.overshoot)
                    report_mismatch("overshoot", out_rsp.overshoot, want.overshoot);
                if (out_rsp.pending_count !== want.pending_count)
                    report_mismatch("pending_count", 32'(out_rsp.pending_count),
                                    32'(want.pending_count));
                if (out_rsp.status !== want.status)
                    report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
                if (want.fired)
                    fired_seen++;
                if (want.status)
                    full_seen++;
            end
        end
    end

    // Watchdog on cycle count.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("timed_event_heap_scheduler_tb: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (pending_reqs.size() > 0 || in_req.valid || expected_rsps.size() > 0)
                @(posedge clk);
        end
    endtask

    // Random phase: schedules and ticks in random order, in roughly equal shares,
    // with some noise including the unused action code and clears.
    task automatic queue_random(input int count);
        int mode;
        begin
            for (int n = 0; n < count; n++) begin
                mode = $urandom_range(0, 99);
                if (mode < 45)
                    pending_reqs.push_back(make_req(ACT_SCHEDULE, rand_delay(),
                                                    16'($urandom()), rand_tick()));
                else if (mode < 93)
                    pending_reqs.push_back(make_req(ACT_TICK, rand_delay(),
                                                    16'($urandom()), rand_tick()));
                else if (mode < 96)
                    pending_reqs.push_back(make_req(ACT_CLEAR, $urandom(),
                                                    16'($urandom()), 31'($urandom())));
                else
                    pending_reqs.push_back(make_req(ACT_UNUSED, $urandom(),
                                                    16'($urandom()), 31'($urandom())));
            end
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        fired_seen = 0;
        full_seen = 0;
        model_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_req.valid = 1'b0;
        in_req.action = ACT_CLEAR;
        in_req.delay_cycles = '0;
        in_req.event_id = '0;
        in_req.tick_amount = '0;
        out_rsp.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: tick on an empty heap, equal keys, extremes, saturation.
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd5));
        pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'h7FFF_FFFF, 16'hFFFF, 31'd0));
        pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'h8000_0000, 16'h0000, 31'd0));
        pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'd10, 16'h1234, 31'h7FFF_FFFF));
        pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'd10, 16'h4321, 31'd0));
        pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'd0, 16'h00AA, 31'd0));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'h7FFF_FFFF));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd0));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd10));
        pending_reqs.push_back(make_req(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd1));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd1));
        pending_reqs.push_back(make_req(ACT_CLEAR, 32'd0, 16'd0, 31'd0));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd1));
        // Overfill the heap so the last two schedules are dropped.
        for (int i = 0; i < CAPACITY + 2; i++)
            pending_reqs.push_back(make_req(ACT_SCHEDULE, 32'($urandom_range(0, 99)),
                                            16'(i), 31'd0));
        pending_reqs.push_back(make_req(ACT_TICK, 32'd0, 16'd0, 31'd50));
        pending_reqs.push_back(make_req(ACT_CLEAR, 32'd0, 16'd0, 31'd0));

        // Sender pauses here until every expected response has arrived.
        wait_drained();

        // Four idling phases over the random requests.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 25) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 25) : 0;
            queue_random(450);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        $display("covered directed extremes and %0d random requests in four idling phases;",
                 4 * 450);
        $display("%0d events fired, %0d schedules dropped on a full heap", fired_seen,
                 full_seen);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("timed_event_heap_scheduler_tb: done, clean");
        else
            $display("timed_event_heap_scheduler_tb: done, errors");
        $finish;
    end
endmodule
